FILE: sv/wto_pkg.sv
// ----------------------------------------------------------------------------
// wto_pkg: shared types and constants
// Field widths, register indexes, mode and opcode codes, the controller state
// type and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package wto_pkg;

  localparam int TABLE_BITS_DEF = 13;
  localparam int FRAC_BITS      = 16;
  localparam int SAMPLE_BITS    = 16;
  localparam int GAIN_FRAC      = 12;
  localparam int MOD_SHIFT      = 32 - FRAC_BITS;

  // payload field widths
  localparam int FM_W     = 24;
  localparam int ADDR_W   = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 29;

  // configuration register widths
  localparam int INC_W    = 29;
  localparam int TSL_W    = 4;
  localparam int MODE_W   = 2;
  localparam int GAIN_W   = 16;
  localparam int MSCALE_W = 24;
  localparam int VLEN_W   = 13;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_LOG2 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_SCALE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VEC_LEN    = 3'd5;

  // register reset values
  localparam logic [INC_W-1:0]    RST_PHASE_INC  = 29'd5242880;
  localparam logic [TSL_W-1:0]    RST_TABLE_LOG2 = 4'd13;
  localparam logic [MODE_W-1:0]   RST_MODE       = 2'd1;
  localparam logic [GAIN_W-1:0]   RST_GAIN       = 16'd4096;
  localparam logic [MSCALE_W-1:0] RST_MOD_SCALE  = 24'd3117;
  localparam logic [VLEN_W-1:0]   RST_VEC_LEN    = 13'd64;

  // interpolation modes
  localparam logic [MODE_W-1:0] MODE_NEAREST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LINEAR  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LFO     = 2'd2;

  // opcodes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RD1,
    S_RD2,
    S_MUL1,
    S_MUL2,
    S_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic rd2;
    logic mul1;
    logic mul2;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic is_write;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: sv/wto_in_if.sv
// ----------------------------------------------------------------------------
// wto_in_if: input item channel
// Valid/ready channel carrying one oscillator command item.
// ----------------------------------------------------------------------------
interface wto_in_if;
  logic                               valid;
  logic                               ready;
  logic                               opcode;
  logic signed [wto_pkg::FM_W-1:0]        fm_offset;
  logic                               fm_enable;
  logic        [wto_pkg::ADDR_W-1:0]      table_address;
  logic signed [wto_pkg::SAMPLE_BITS-1:0] table_data;

  modport source (
    output valid, opcode, fm_offset, fm_enable, table_address, table_data,
    input  ready
  );
  modport sink (
    input  valid, opcode, fm_offset, fm_enable, table_address, table_data,
    output ready
  );
endinterface

FILE: sv/wto_out_if.sv
// ----------------------------------------------------------------------------
// wto_out_if: result item channel
// Valid/ready channel carrying one output sample and its clip flag.
// ----------------------------------------------------------------------------
interface wto_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [wto_pkg::SAMPLE_BITS-1:0] sample;
  logic                                   clipped;

  modport source (output valid, sample, clipped, input ready);
  modport sink   (input valid, sample, clipped, output ready);
endinterface

FILE: sv/wto_cfg_if.sv
// ----------------------------------------------------------------------------
// wto_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface wto_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [wto_pkg::CFG_IDX_W-1:0]     reg_idx;
  logic [wto_pkg::CFG_DATA_W-1:0]    wdata;

  modport source (output valid, reg_idx, wdata, input ready);
  modport sink   (input valid, reg_idx, wdata, output ready);
endinterface

FILE: sv/wavetable_oscillator_core.sv
// Flow: a tick item steps through EXEC, RD1, RD2, MUL1, MUL2 and OUT;
//   OUT holds while the output register is full. A new item is taken
//   only once the last is through; the single read port of the table
//   (two reads per tick) and the two-step blend/gain multiply chain set this.
// Reset: synchronous, active low; registers go to defaults, phase to zero,
//   the table is not cleared.
// ----------------------------------------------------------------------------
// wavetable_oscillator_core: phase-accumulator wavetable oscillator
// Table writes, FM-capable phase accumulator, nearest/linear/LFO readout,
// gain with rounding and saturation.
// ----------------------------------------------------------------------------
module wavetable_oscillator_core #(
  parameter int TABLE_BITS = wto_pkg::TABLE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  wto_in_if.sink    in_ch,
  wto_out_if.source out_ch,
  wto_cfg_if.sink   cfg_ch
);

  wto_pkg::dp_cmd_t  cmd;
  wto_pkg::dp_stat_t stat;
  logic              in_ready;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  wto_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  wto_dp #(
    .TABLE_BITS (TABLE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_ch.valid),
    .cfg_idx          (cfg_ch.reg_idx),
    .cfg_data         (cfg_ch.wdata),
    .in_opcode        (in_ch.opcode),
    .in_fm_offset     (in_ch.fm_offset),
    .in_fm_enable     (in_ch.fm_enable),
    .in_table_address (in_ch.table_address),
    .in_table_data    (in_ch.table_data),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_sample       (out_ch.sample),
    .out_clipped      (out_ch.clipped),
    .cmd              (cmd),
    .stat             (stat)
  );

endmodule

FILE: sv/wto_ram.sv
// ----------------------------------------------------------------------------
// wto_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module wto_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/wto_ctrl.sv
// ----------------------------------------------------------------------------
// wto_ctrl: oscillator sequencer
// Walks one item: a table write, or phase update, two table reads, blend, gain.
// ----------------------------------------------------------------------------
module wto_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  wto_pkg::dp_stat_t  stat,
  output wto_pkg::dp_cmd_t   cmd
);

  wto_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wto_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wto_pkg::S_IDLE: begin
        if (in_valid) state_nxt = wto_pkg::S_EXEC;
      end
      wto_pkg::S_EXEC: begin
        state_nxt = stat.is_write ? wto_pkg::S_IDLE : wto_pkg::S_RD1;
      end
      wto_pkg::S_RD1:  state_nxt = wto_pkg::S_RD2;
      wto_pkg::S_RD2:  state_nxt = wto_pkg::S_MUL1;
      wto_pkg::S_MUL1: state_nxt = wto_pkg::S_MUL2;
      wto_pkg::S_MUL2: state_nxt = wto_pkg::S_OUT;
      wto_pkg::S_OUT: begin
        // hold until the output register can take the item
        if (stat.out_free) state_nxt = wto_pkg::S_IDLE;
      end
      default: state_nxt = wto_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      wto_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      wto_pkg::S_EXEC: cmd.exec = 1'b1;
      wto_pkg::S_RD1:  cmd.exec = 1'b0;
      wto_pkg::S_RD2:  cmd.rd2  = 1'b1;
      wto_pkg::S_MUL1: cmd.mul1 = 1'b1;
      wto_pkg::S_MUL2: cmd.mul2 = 1'b1;
      wto_pkg::S_OUT:  cmd.load_out = stat.out_free;
      default:         cmd = '0;
    endcase
  end

endmodule

FILE: sv/wto_dp.sv
// ----------------------------------------------------------------------------
// wto_dp: oscillator datapath
// Configuration registers, phase accumulator, wave table, blend and gain
// multipliers, rounding and saturation, and the output register.
// ----------------------------------------------------------------------------
module wto_dp #(
  parameter int TABLE_BITS = wto_pkg::TABLE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // configuration
  input  logic                                   cfg_we,
  input  logic [wto_pkg::CFG_IDX_W-1:0]          cfg_idx,
  input  logic [wto_pkg::CFG_DATA_W-1:0]         cfg_data,
  // input item
  input  logic                                   in_opcode,
  input  logic signed [wto_pkg::FM_W-1:0]        in_fm_offset,
  input  logic                                   in_fm_enable,
  input  logic [wto_pkg::ADDR_W-1:0]             in_table_address,
  input  logic signed [wto_pkg::SAMPLE_BITS-1:0] in_table_data,
  // result item
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [wto_pkg::SAMPLE_BITS-1:0] out_sample,
  output logic                                   out_clipped,
  // sequencer
  input  wto_pkg::dp_cmd_t                       cmd,
  output wto_pkg::dp_stat_t                      stat
);

  localparam int FB    = wto_pkg::FRAC_BITS;
  localparam int SB    = wto_pkg::SAMPLE_BITS;
  localparam int PH_W  = TABLE_BITS + FB;
  localparam int LG_W  = $clog2(TABLE_BITS + 1);
  localparam int V_W   = SB + FB + 2;
  localparam int P_W   = V_W + wto_pkg::GAIN_W + 1;
  localparam int RSH   = FB + wto_pkg::GAIN_FRAC;
  localparam int FMP_W = wto_pkg::FM_W + wto_pkg::MSCALE_W + 1;
  localparam int LFO_W = wto_pkg::INC_W + wto_pkg::VLEN_W;

  // configuration registers
  logic [wto_pkg::INC_W-1:0]    inc_r;
  logic [wto_pkg::TSL_W-1:0]    tsl_r;
  logic [wto_pkg::MODE_W-1:0]   mode_r;
  logic [wto_pkg::GAIN_W-1:0]   gain_r;
  logic [wto_pkg::MSCALE_W-1:0] mscale_r;
  logic [wto_pkg::VLEN_W-1:0]   vlen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inc_r    <= wto_pkg::RST_PHASE_INC;
      tsl_r    <= wto_pkg::RST_TABLE_LOG2;
      mode_r   <= wto_pkg::RST_MODE;
      gain_r   <= wto_pkg::RST_GAIN;
      mscale_r <= wto_pkg::RST_MOD_SCALE;
      vlen_r   <= wto_pkg::RST_VEC_LEN;
    end else if (cfg_we) begin
      case (cfg_idx)
        wto_pkg::REG_PHASE_INC:  inc_r    <= cfg_data[wto_pkg::INC_W-1:0];
        wto_pkg::REG_TABLE_LOG2: tsl_r    <= cfg_data[wto_pkg::TSL_W-1:0];
        wto_pkg::REG_MODE:       mode_r   <= cfg_data[wto_pkg::MODE_W-1:0];
        wto_pkg::REG_GAIN:       gain_r   <= cfg_data[wto_pkg::GAIN_W-1:0];
        wto_pkg::REG_MOD_SCALE:  mscale_r <= cfg_data[wto_pkg::MSCALE_W-1:0];
        wto_pkg::REG_VEC_LEN:    vlen_r   <= cfg_data[wto_pkg::VLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // captured item
  logic                        op_r;
  logic signed [wto_pkg::FM_W-1:0] fm_r;
  logic                        fm_en_r;
  logic [TABLE_BITS-1:0]       addr_r;
  logic [SB-1:0]               data_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_opcode;
      fm_r    <= in_fm_offset;
      fm_en_r <= in_fm_enable;
      addr_r  <= TABLE_BITS'(in_table_address);
      data_r  <= in_table_data;
    end
  end

  assign stat.is_write = (op_r == wto_pkg::OP_WRITE);

  // active table length, clamped to the built range
  logic [LG_W-1:0]       lg;
  logic [LG_W-1:0]       shamt;
  logic [TABLE_BITS-1:0] len_mask;
  logic [PH_W-1:0]       ph_mask;

  always_comb begin
    if (tsl_r < wto_pkg::TSL_W'(2)) begin
      lg = LG_W'(2);
    end else if (32'(tsl_r) > TABLE_BITS) begin
      lg = LG_W'(TABLE_BITS);
    end else begin
      lg = LG_W'(tsl_r);
    end
    shamt    = LG_W'(TABLE_BITS) - lg;
    len_mask = {TABLE_BITS{1'b1}} >> shamt;
    ph_mask  = {PH_W{1'b1}} >> shamt;
  end

  // phase update
  logic [PH_W-1:0]              phase_r;
  logic [TABLE_BITS-1:0]        idx_r;
  logic [FB-1:0]                frac_r;
  logic                         lin_r;
  logic signed [FMP_W-1:0]      fm_prod;
  logic signed [FMP_W-1:0]      fm_sh;
  logic [LFO_W-1:0]             lfo_step;
  logic [PH_W-1:0]              mod_ph;
  logic [PH_W-1:0]              phase_nxt;
  logic [PH_W-1:0]              idx_src;
  logic                         is_lfo;

  always_comb begin
    is_lfo   = (mode_r == wto_pkg::MODE_LFO);
    fm_prod  = fm_r * $signed({1'b0, mscale_r});
    // arithmetic shift rounds toward minus infinity
    fm_sh    = fm_prod >>> wto_pkg::MOD_SHIFT;
    mod_ph   = fm_en_r ? fm_sh[PH_W-1:0] : '0;
    lfo_step = inc_r * vlen_r;
    if (is_lfo) begin
      phase_nxt = (phase_r + lfo_step[PH_W-1:0]) & ph_mask;
      idx_src   = phase_r;
    end else begin
      phase_nxt = (phase_r + PH_W'(inc_r) + mod_ph) & ph_mask;
      idx_src   = phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (cmd.exec && !stat.is_write) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      idx_r  <= idx_src[PH_W-1:FB] & len_mask;
      frac_r <= idx_src[FB-1:0];
      lin_r  <= (mode_r == wto_pkg::MODE_LINEAR);
    end
  end

  // wave table
  logic [TABLE_BITS-1:0] idx_inc;
  logic [TABLE_BITS-1:0] raddr;
  logic [SB-1:0]         rdata;

  assign idx_inc = (idx_r + TABLE_BITS'(1)) & len_mask;
  assign raddr   = cmd.rd2 ? idx_inc : idx_r;

  wto_ram #(
    .WIDTH (SB),
    .DEPTH (1 << TABLE_BITS)
  ) u_table (
    .clk   (clk),
    .we    (cmd.exec && stat.is_write),
    .waddr (addr_r),
    .wdata (data_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  // blend: t1 * 2^F + (t2 - t1) * f, then gain
  logic signed [SB-1:0]   t1_r;
  logic signed [SB:0]     diff;
  logic signed [V_W-1:0]  dterm;
  logic signed [V_W-1:0]  t1_sh;
  logic signed [V_W-1:0]  v_r;
  logic signed [P_W-1:0]  prod_r;

  always_comb begin
    diff  = $signed({rdata[SB-1], rdata}) - $signed({t1_r[SB-1], t1_r});
    dterm = lin_r ? V_W'(diff * $signed({1'b0, frac_r})) : '0;
    t1_sh = {{(V_W-SB-FB){t1_r[SB-1]}}, t1_r, {FB{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (cmd.rd2) begin
      t1_r <= rdata;
    end
    if (cmd.mul1) begin
      v_r <= t1_sh + dterm;
    end
    if (cmd.mul2) begin
      prod_r <= v_r * $signed({1'b0, gain_r});
    end
  end

  // round half up, then saturate
  logic signed [P_W-1:0] rnd;
  logic signed [P_W-1:0] shd;
  logic signed [P_W-1:0] max_v;
  logic signed [P_W-1:0] min_v;
  logic [SB-1:0]         sat_val;
  logic                  sat_clip;

  always_comb begin
    max_v = $signed({{(P_W-SB+1){1'b0}}, {(SB-1){1'b1}}});
    min_v = ~max_v;
    rnd   = prod_r + $signed({{(P_W-RSH){1'b0}}, 1'b1, {(RSH-1){1'b0}}});
    shd   = rnd >>> RSH;
    if (shd > max_v) begin
      sat_val  = max_v[SB-1:0];
      sat_clip = 1'b1;
    end else if (shd < min_v) begin
      sat_val  = min_v[SB-1:0];
      sat_clip = 1'b1;
    end else begin
      sat_val  = shd[SB-1:0];
      sat_clip = 1'b0;
    end
  end

  // output register
  logic          out_valid_r;
  logic [SB-1:0] out_sample_r;
  logic          out_clip_r;

  assign stat.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_sample_r <= sat_val;
      out_clip_r   <= sat_clip;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_sample  = $signed(out_sample_r);
  assign out_clipped = out_clip_r;

endmodule

FILE: sv/wto_checker.sv
// ----------------------------------------------------------------------------
// wto_checker: port-level checks for the oscillator core
// Watches the item channels over time; bound to the top level.
// ----------------------------------------------------------------------------
module wto_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [wto_pkg::SAMPLE_BITS-1:0] sample,
  input logic                           clipped
);

  localparam int SB = wto_pkg::SAMPLE_BITS;

  // a waiting result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a waiting result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(sample) && $stable(clipped))
    else $error("stalled result changed");

  // one item at a time: no accept on the cycle right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while previous item in flight");

  // a clipped sample sits on a rail
  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && clipped |->
      sample == {1'b0, {(SB-1){1'b1}}} || sample == {1'b1, {(SB-1){1'b0}}})
    else $error("clip flag set on an in-range sample");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind wavetable_oscillator_core wto_checker u_wto_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .sample    (out_ch.sample),
  .clipped   (out_ch.clipped)
);
